[rtl/vrfc_pkg.sv]
// shared types and codes for the region fault classifier
package vrfc_pkg;

  localparam int ADDR_W   = 48;
  localparam int OP_W     = 2;
  localparam int FLAG_W   = 3;
  localparam int IDX_W    = 4;
  localparam int STATUS_W = 4;
  localparam int HIT_W    = 4;

  localparam logic [OP_W-1:0] OP_ADD   = 2'd0;
  localparam logic [OP_W-1:0] OP_FAULT = 2'd1;
  localparam logic [OP_W-1:0] OP_NOTE  = 2'd2;

  localparam int FLAG_WRITE = 0;
  localparam int FLAG_DOWN  = 1;
  localparam int FLAG_UP    = 2;

  localparam logic [STATUS_W-1:0] ST_DONE         = 4'd0;
  localparam logic [STATUS_W-1:0] ST_REJECT       = 4'd1;
  localparam logic [STATUS_W-1:0] ST_UNHANDLED    = 4'd2;
  localparam logic [STATUS_W-1:0] ST_NO_REGION    = 4'd3;
  localparam logic [STATUS_W-1:0] ST_WRITE_DENIED = 4'd4;
  localparam logic [STATUS_W-1:0] ST_OUTSIDE      = 4'd5;
  localparam logic [STATUS_W-1:0] ST_COMMITTED    = 4'd6;
  localparam logic [STATUS_W-1:0] ST_COMMIT       = 4'd7;
  localparam logic [STATUS_W-1:0] ST_NO_POLICY    = 4'd8;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [ADDR_W-1:0] address;
    logic [ADDR_W-1:0] length;
    logic [FLAG_W-1:0] region_flags;
    logic [IDX_W-1:0]  region_index;
    logic              page_present;
    logic              write_access;
    logic              user_mode;
  } in_word_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ADDR_W-1:0]   page_addr;
    logic [HIT_W-1:0]    hit_index;
    logic                page_writable;
  } out_word_t;

  typedef enum logic [2:0] {
    RES_REJECT,
    RES_UNHANDLED,
    RES_NO_REGION,
    RES_ADD_DONE,
    RES_NOTE_DONE,
    RES_FAULT
  } res_kind_t;

  typedef struct packed {
    logic      req_load;
    logic      add_write;
    logic      scan_start;
    logic      scan_step;
    logic      note_read;
    logic      note_write;
    logic      res_load;
    res_kind_t res_kind;
    logic      out_load;
  } ctl_cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            add_ok;
    logic            note_ok;
    logic            fault_ok;
    logic            scan_hit;
    logic            scan_done;
    logic            out_free;
  } ctl_sts_t;

endpackage

[rtl/vm_region_fault_classifier_core.sv]
// top level of the region fault classifier
// Each input word is one request: add a region, classify a page fault or note a
// mapped range. One result word comes back per request, in order. A fault that
// passes the present and user checks scans the regions in order up to the first
// match (or through all regions when none matches), because the region table
// sits in one memory with a single read port and is compared one entry per
// cycle. The result sits in an output register, so the next word is taken while
// a finished result still waits. Table contents need no clearing after reset;
// only entries below the region count are ever read.
module vm_region_fault_classifier_core #(
  parameter int MAX_REGIONS = 16,
  parameter int PAGE_BYTES  = 4096,
  parameter int ADDR_BITS   = 48
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  vrfc_pkg::in_word_t  in_word,
  output logic                out_valid,
  input  logic                out_stall,
  output vrfc_pkg::out_word_t out_word
);
  import vrfc_pkg::*;

  ctl_cmd_t cmd;
  ctl_sts_t sts;

  vrfc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  vrfc_dpath #(
    .MAX_REGIONS (MAX_REGIONS),
    .PAGE_BYTES  (PAGE_BYTES),
    .ADDR_BITS   (ADDR_BITS)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_word   (in_word),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

endmodule

[rtl/vrfc_ctrl.sv]
// controller state machine for the region fault classifier
module vrfc_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  vrfc_pkg::ctl_sts_t sts,
  output vrfc_pkg::ctl_cmd_t cmd
);
  import vrfc_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_SCAN,
    S_NOTE_WR,
    S_FINISH
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    in_stall  = 1'b1;
    unique case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.req_load = 1'b1;
          state_nxt    = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        state_nxt = S_FINISH;
        unique case (sts.op)
          OP_ADD: begin
            cmd.res_load = 1'b1;
            if (sts.add_ok) begin
              cmd.add_write = 1'b1;
              cmd.res_kind  = RES_ADD_DONE;
            end else begin
              cmd.res_kind = RES_REJECT;
            end
          end
          OP_FAULT: begin
            if (sts.fault_ok) begin
              cmd.scan_start = 1'b1;
              state_nxt      = S_SCAN;
            end else begin
              cmd.res_load = 1'b1;
              cmd.res_kind = RES_UNHANDLED;
            end
          end
          OP_NOTE: begin
            if (sts.note_ok) begin
              cmd.note_read = 1'b1;
              state_nxt     = S_NOTE_WR;
            end else begin
              cmd.res_load = 1'b1;
              cmd.res_kind = RES_REJECT;
            end
          end
          default: begin
            cmd.res_load = 1'b1;
            cmd.res_kind = RES_REJECT;
          end
        endcase
      end
      S_SCAN: begin
        if (sts.scan_hit) begin
          cmd.res_load = 1'b1;
          cmd.res_kind = RES_FAULT;
          state_nxt    = S_FINISH;
        end else if (sts.scan_done) begin
          cmd.res_load = 1'b1;
          cmd.res_kind = RES_NO_REGION;
          state_nxt    = S_FINISH;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      S_NOTE_WR: begin
        cmd.note_write = 1'b1;
        cmd.res_load   = 1'b1;
        cmd.res_kind   = RES_NOTE_DONE;
        state_nxt      = S_FINISH;
      end
      S_FINISH: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

[rtl/vrfc_dpath.sv]
// region table, scan compare, classification and result register
module vrfc_dpath #(
  parameter int MAX_REGIONS = 16,
  parameter int PAGE_BYTES  = 4096,
  parameter int ADDR_BITS   = 48
) (
  input  logic                clk,
  input  logic                rst_n,
  input  vrfc_pkg::in_word_t  in_word,
  input  vrfc_pkg::ctl_cmd_t  cmd,
  output vrfc_pkg::ctl_sts_t  sts,
  output logic                out_valid,
  input  logic                out_stall,
  output vrfc_pkg::out_word_t out_word
);
  import vrfc_pkg::*;

  localparam int AW = (ADDR_BITS < ADDR_W) ? ADDR_BITS : ADDR_W;
  localparam int IW = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
  localparam int CW = $clog2(MAX_REGIONS + 1);
  localparam int RW = (CW > IDX_W) ? CW : IDX_W;
  localparam int XW = (IW > IDX_W) ? IW : IDX_W;
  localparam int PB = $clog2(PAGE_BYTES);

  typedef struct packed {
    logic [AW-1:0]     base;
    logic [AW:0]       limit;
    logic [FLAG_W-1:0] flags;
    logic [AW:0]       clow;
    logic [AW:0]       chigh;
  } ent_t;

  ent_t mem [MAX_REGIONS];

  in_word_t  req_r;
  logic [CW-1:0] count_r;
  logic [CW-1:0] scan_idx_r;
  logic          cmp_vld_r;
  logic [IW-1:0] cmp_idx_r;
  ent_t          rd_data_r;
  out_word_t     res_r, res_nxt;
  logic          out_valid_r;
  out_word_t     out_r;

  logic [AW-1:0] addr_a, len_a, aligned_a;
  logic [AW:0]   addr_x, sum_a, aligned_x;
  logic [XW-1:0] ridx_x;
  logic [IW-1:0] ridx_i;
  logic          scan_lt, match;
  logic          rd_en, wr_en;
  logic [IW-1:0] rd_idx, wr_idx;
  ent_t          wr_data;
  logic [STATUS_W-1:0] fst;
  logic [FLAG_W-1:0]   f;

  assign addr_a    = req_r.address[AW-1:0];
  assign len_a     = req_r.length[AW-1:0];
  assign addr_x    = {1'b0, addr_a};
  assign sum_a     = addr_x + {1'b0, len_a};
  assign aligned_a = {addr_a[AW-1:PB], {PB{1'b0}}};
  assign aligned_x = {1'b0, aligned_a};
  assign ridx_x    = XW'(req_r.region_index);
  assign ridx_i    = ridx_x[IW-1:0];
  assign scan_lt   = scan_idx_r < count_r;
  assign f         = rd_data_r.flags;
  assign match     = (addr_x >= {1'b0, rd_data_r.base}) && (addr_x < rd_data_r.limit);

  assign sts.op        = req_r.op;
  assign sts.add_ok    = (len_a != '0) && (count_r < CW'(MAX_REGIONS));
  assign sts.note_ok   = (len_a != '0) && (RW'(req_r.region_index) < RW'(count_r));
  assign sts.fault_ok  = req_r.user_mode && !req_r.page_present;
  assign sts.scan_hit  = cmp_vld_r && match;
  assign sts.scan_done = !cmp_vld_r && !scan_lt;
  assign sts.out_free  = !out_valid_r || !out_stall;

  assign rd_en  = cmd.note_read || (cmd.scan_step && scan_lt);
  assign rd_idx = cmd.note_read ? ridx_i : scan_idx_r[IW-1:0];
  assign wr_en  = cmd.add_write || cmd.note_write;
  assign wr_idx = cmd.add_write ? count_r[IW-1:0] : ridx_i;

  always_comb begin
    if (cmd.add_write) begin
      wr_data.base  = addr_a;
      wr_data.limit = sum_a;
      wr_data.flags = req_r.region_flags;
      wr_data.clow  = req_r.region_flags[FLAG_DOWN] ? sum_a : addr_x;
      wr_data.chigh = req_r.region_flags[FLAG_DOWN] ? sum_a : addr_x;
    end else begin
      wr_data       = rd_data_r;
      wr_data.clow  = (addr_x < rd_data_r.clow) ? addr_x : rd_data_r.clow;
      wr_data.chigh = (sum_a > rd_data_r.chigh) ? sum_a : rd_data_r.chigh;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_idx];
    end
  end

  // fault classification against the entry under compare
  always_comb begin
    fst = ST_NO_POLICY;
    if (req_r.write_access && !f[FLAG_WRITE]) begin
      fst = ST_WRITE_DENIED;
    end else if (f[FLAG_DOWN]) begin
      if (aligned_a < rd_data_r.base) begin
        fst = ST_OUTSIDE;
      end else if (rd_data_r.clow <= aligned_x) begin
        fst = ST_COMMITTED;
      end else begin
        fst = ST_COMMIT;
      end
    end else if (f[FLAG_UP]) begin
      if (aligned_x >= rd_data_r.limit) begin
        fst = ST_OUTSIDE;
      end else if (rd_data_r.chigh > aligned_x) begin
        fst = ST_COMMITTED;
      end else begin
        fst = ST_COMMIT;
      end
    end
  end

  always_comb begin
    res_nxt = '0;
    unique case (cmd.res_kind)
      RES_REJECT:    res_nxt.status = ST_REJECT;
      RES_UNHANDLED: res_nxt.status = ST_UNHANDLED;
      RES_NO_REGION: res_nxt.status = ST_NO_REGION;
      RES_ADD_DONE: begin
        res_nxt.status    = ST_DONE;
        res_nxt.hit_index = HIT_W'(count_r);
      end
      RES_NOTE_DONE: begin
        res_nxt.status    = ST_DONE;
        res_nxt.hit_index = req_r.region_index;
      end
      RES_FAULT: begin
        res_nxt.status        = fst;
        res_nxt.page_addr     = (fst == ST_COMMIT) ? ADDR_W'(aligned_a) : '0;
        res_nxt.hit_index     = HIT_W'(cmp_idx_r);
        res_nxt.page_writable = f[FLAG_WRITE];
      end
      default: res_nxt.status = ST_REJECT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.req_load) begin
      req_r <= in_word;
    end
    if (cmd.res_load) begin
      res_r <= res_nxt;
    end
    if (cmd.out_load) begin
      out_r <= res_r;
    end
    if (cmd.scan_step && scan_lt) begin
      cmp_idx_r <= scan_idx_r[IW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      scan_idx_r  <= '0;
      cmp_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.add_write) begin
        count_r <= count_r + 1'b1;
      end
      if (cmd.scan_start) begin
        scan_idx_r <= '0;
        cmp_vld_r  <= 1'b0;
      end else if (cmd.scan_step) begin
        cmp_vld_r <= scan_lt;
        if (scan_lt) begin
          scan_idx_r <= scan_idx_r + 1'b1;
        end
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_r;

endmodule

[dv/vm_region_fault_classifier_core_test.sv]
// testbench for the region fault classifier: directed and random requests checked against a table model
module vm_region_fault_classifier_core_test;
  import vrfc_pkg::*;

  localparam int NUM_REGIONS  = 16;
  localparam int PAGE_SZ      = 4096;
  localparam int IDLE_LIMIT   = 2000;
  localparam int DRAIN_CYCLES = 24;

  localparam logic [OP_W-1:0]   OP_UNUSED = 2'd3;
  localparam logic [ADDR_W-1:0] PAGE_OFS  = ADDR_W'(PAGE_SZ - 1);
  localparam logic [ADDR_W-1:0] ADDR_MAX  = '1;
  localparam logic [FLAG_W-1:0] RF_WR     = FLAG_W'(1 << FLAG_WRITE);
  localparam logic [FLAG_W-1:0] RF_DOWN   = FLAG_W'(1 << FLAG_DOWN);
  localparam logic [FLAG_W-1:0] RF_UP     = FLAG_W'(1 << FLAG_UP);

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_word_t  in_word = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_word_t out_word;

  // region table as the block should hold it
  logic [ADDR_W-1:0] tbl_base [NUM_REGIONS];
  logic [ADDR_W-1:0] tbl_len [NUM_REGIONS];
  logic [FLAG_W-1:0] tbl_flags [NUM_REGIONS];
  logic [ADDR_W:0]   tbl_low [NUM_REGIONS];
  logic [ADDR_W:0]   tbl_high [NUM_REGIONS];
  int                region_count = 0;

  out_word_t pending_verdicts [$];
  out_word_t last_verdict;
  int        errors = 0;
  int        idle_cycles = 0;
  int        stall_left = 0;
  bit        idle_on = 1'b1;

  vm_region_fault_classifier_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

  always #4 clk = ~clk;

  function automatic logic [ADDR_W:0] entry_limit(int i);
    return {1'b0, tbl_base[i]} + {1'b0, tbl_len[i]};
  endfunction

  function automatic out_word_t classify_request(in_word_t w);
    out_word_t         r;
    logic [ADDR_W:0]   lim;
    logic [ADDR_W-1:0] aligned;
    int                hit;
    r = '0;
    r.status = ST_REJECT;
    lim = {1'b0, w.address} + {1'b0, w.length};
    case (w.op)
      OP_ADD: begin
        if (w.length != 0 && region_count < NUM_REGIONS) begin
          tbl_base[region_count]  = w.address;
          tbl_len[region_count]   = w.length;
          tbl_flags[region_count] = w.region_flags;
          tbl_low[region_count]   = w.region_flags[FLAG_DOWN] ? lim : {1'b0, w.address};
          tbl_high[region_count]  = tbl_low[region_count];
          r.status = ST_DONE;
          r.hit_index = HIT_W'(region_count);
          region_count++;
        end
      end
      OP_FAULT: begin
        if (w.page_present || !w.user_mode) begin
          r.status = ST_UNHANDLED;
        end else begin
          hit = -1;
          for (int i = 0; i < region_count; i++)
            if (hit < 0 && w.address >= tbl_base[i] && {1'b0, w.address} < entry_limit(i))
              hit = i;
          if (hit < 0) begin
            r.status = ST_NO_REGION;
          end else begin
            aligned = w.address & ~PAGE_OFS;
            r.hit_index = HIT_W'(hit);
            r.page_writable = tbl_flags[hit][FLAG_WRITE];
            if (w.write_access && !tbl_flags[hit][FLAG_WRITE]) begin
              r.status = ST_WRITE_DENIED;
            end else if (tbl_flags[hit][FLAG_DOWN]) begin
              if (aligned < tbl_base[hit]) r.status = ST_OUTSIDE;
              else if (tbl_low[hit] <= {1'b0, aligned}) r.status = ST_COMMITTED;
              else r.status = ST_COMMIT;
            end else if (tbl_flags[hit][FLAG_UP]) begin
              if ({1'b0, aligned} >= entry_limit(hit)) r.status = ST_OUTSIDE;
              else if (tbl_high[hit] > {1'b0, aligned}) r.status = ST_COMMITTED;
              else r.status = ST_COMMIT;
            end else begin
              r.status = ST_NO_POLICY;
            end
            if (r.status == ST_COMMIT) r.page_addr = aligned;
          end
        end
      end
      OP_NOTE: begin
        if (w.length != 0 && w.region_index < region_count) begin
          if ({1'b0, w.address} < tbl_low[w.region_index])
            tbl_low[w.region_index] = {1'b0, w.address};
          if (lim > tbl_high[w.region_index]) tbl_high[w.region_index] = lim;
          r.status = ST_DONE;
          r.hit_index = w.region_index;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic send_request(in_word_t w);
    bit taken;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    do begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end while (!taken);
    last_verdict = classify_request(w);
    pending_verdicts.push_back(last_verdict);
  endtask

  task automatic check_field(string name, logic [ADDR_W-1:0] want, logic [ADDR_W-1:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
    end
  endtask

  // result words are taken at the next rising edge; sample while stable
  always @(negedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (pending_verdicts.size() == 0) begin
          errors++;
          $display("%0t: unexpected result word, expected none, actual %h", $time, out_word);
        end else begin
          check_field("status", pending_verdicts[0].status, out_word.status);
          check_field("page_addr", pending_verdicts[0].page_addr, out_word.page_addr);
          check_field("hit_index", pending_verdicts[0].hit_index, out_word.hit_index);
          check_field("page_writable", pending_verdicts[0].page_writable,
                      out_word.page_writable);
          void'(pending_verdicts.pop_front());
        end
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("vm_region_fault_classifier_core test failed");
        $finish;
      end
    end
  end

  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (idle_on && $urandom_range(0, 4) == 0) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 5);
    end else begin
      out_stall <= 1'b0;
    end
  end

  function automatic in_word_t make_request(logic [OP_W-1:0] op, logic [ADDR_W-1:0] addr,
                                            logic [ADDR_W-1:0] len, logic [FLAG_W-1:0] flags,
                                            logic [IDX_W-1:0] idx, logic present,
                                            logic wr, logic user);
    in_word_t w;
    w.op = op;
    w.address = addr;
    w.length = len;
    w.region_flags = flags;
    w.region_index = idx;
    w.page_present = present;
    w.write_access = wr;
    w.user_mode = user;
    return w;
  endfunction

  function automatic logic [ADDR_W-1:0] rand_addr();
    logic [63:0] r;
    r = {$urandom(), $urandom()};
    return r[ADDR_W-1:0];
  endfunction

  function automatic logic [ADDR_W-1:0] rand_length();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5:
        return ADDR_W'($urandom_range(1, 64)) * PAGE_SZ +
               ($urandom_range(0, 1) ? ADDR_W'($urandom_range(0, PAGE_SZ - 1)) : '0);
      6, 7: return ADDR_W'($urandom_range(1, PAGE_SZ - 1));
      8: return rand_addr() >> $urandom_range(0, ADDR_W - 1);
      default: return rand_addr();
    endcase
  endfunction

  // mostly requests aimed at existing regions and their committed edges
  function automatic in_word_t random_request();
    in_word_t        w;
    int              pick, add_pct, i;
    logic [ADDR_W:0] bound;
    logic [63:0]     ofs;
    w = make_request(OP_FAULT, rand_addr(), rand_length(), FLAG_W'($urandom_range(0, 7)),
                     IDX_W'($urandom_range(0, 15)), $urandom_range(0, 9) == 0,
                     1'($urandom_range(0, 1)), $urandom_range(0, 9) != 0);
    add_pct = (region_count < NUM_REGIONS) ? 10 : 3;
    pick = $urandom_range(0, 99);
    if (pick < add_pct) begin
      w.op = OP_ADD;
      if (region_count > 0 && $urandom_range(0, 3) == 0)
        w.address = tbl_base[$urandom_range(0, region_count - 1)] +
                    ADDR_W'($urandom_range(0, 8 * PAGE_SZ));
      if ($urandom_range(0, 19) == 0) w.length = '0;
    end else if (pick < add_pct + 3) begin
      w.op = OP_UNUSED;
    end else if (pick < add_pct + 65) begin
      if (region_count > 0 && $urandom_range(0, 4) != 0) begin
        i = $urandom_range(0, region_count - 1);
        if ($urandom_range(0, 1)) begin
          ofs = {$urandom(), $urandom()} % tbl_len[i];
          w.address = tbl_base[i] + ofs[ADDR_W-1:0];
        end else begin
          bound = tbl_flags[i][FLAG_DOWN] ? tbl_low[i] : tbl_high[i];
          bound = bound + (ADDR_W + 1)'($urandom_range(0, 5) * PAGE_SZ) -
                  (ADDR_W + 1)'(3 * PAGE_SZ) +
                  (ADDR_W + 1)'($urandom_range(0, PAGE_SZ - 1));
          w.address = bound[ADDR_W-1:0];
        end
      end
    end else begin
      w.op = OP_NOTE;
      if (region_count > 0 && $urandom_range(0, 4) != 0) begin
        i = $urandom_range(0, region_count - 1);
        w.region_index = IDX_W'(i);
        w.length = ADDR_W'($urandom_range(1, 4) * PAGE_SZ);
        bound = tbl_flags[i][FLAG_DOWN] ? tbl_low[i] - {1'b0, w.length} : tbl_high[i];
        w.address = bound[ADDR_W-1:0];
      end
    end
    return w;
  endfunction

  task automatic test_empty_table();
    send_request(make_request(OP_FAULT, 48'h1000, '0, '0, '0, 1'b0, 1'b0, 1'b1));
    send_request(make_request(OP_NOTE, 48'h1000, 48'h1000, '0, '0, 1'b0, 1'b0, 1'b1));
    send_request(make_request(OP_ADD, 48'h1000, '0, RF_WR, '0, 1'b0, 1'b0, 1'b1));
    send_request(make_request(OP_UNUSED, ADDR_MAX, ADDR_MAX, '1, '1, 1'b1, 1'b1, 1'b1));
    send_request(make_request(OP_FAULT, 48'h1000, '0, '0, '0, 1'b1, 1'b0, 1'b1));
    send_request(make_request(OP_FAULT, 48'h1000, '0, '0, '0, 1'b0, 1'b0, 1'b0));
  endtask

  task automatic test_region_kinds();
    send_request(make_request(OP_ADD, 48'h1000, 48'h4000, RF_WR | RF_UP, '0, 0, 0, 1));
    send_request(make_request(OP_ADD, 48'h1000_0800, 48'h3800, RF_DOWN, '0, 0, 0, 1));
    send_request(make_request(OP_ADD, ADDR_MAX, ADDR_MAX, RF_WR | RF_DOWN | RF_UP, '0, 0, 0, 1));
    send_request(make_request(OP_ADD, 48'h2000_0000, 48'h1000, RF_WR, '0, 0, 0, 1));
    // grow up: commit, note, then already committed; limit is exclusive
    send_request(make_request(OP_FAULT, 48'h1234, '0, '0, '0, 0, 1, 1));
    send_request(make_request(OP_NOTE, 48'h1000, 48'h1000, '0, 4'd0, 0, 0, 1));
    send_request(make_request(OP_FAULT, 48'h1fff, '0, '0, '0, 0, 0, 1));
    send_request(make_request(OP_FAULT, 48'h5000, '0, '0, '0, 0, 0, 1));
    // grow down with unaligned base
    send_request(make_request(OP_FAULT, 48'h1000_3abc, '0, '0, '0, 0, 1, 1));
    send_request(make_request(OP_FAULT, 48'h1000_0900, '0, '0, '0, 0, 0, 1));
    send_request(make_request(OP_FAULT, 48'h1000_3abc, '0, '0, '0, 0, 0, 1));
    send_request(make_request(OP_NOTE, '0, ADDR_MAX, '0, 4'd1, 0, 0, 1));
    send_request(make_request(OP_FAULT, 48'h1000_3abc, '0, '0, '0, 0, 0, 1));
    // both growth flags at the top of the address space, then no growth flag, and rejected notes
    send_request(make_request(OP_FAULT, ADDR_MAX, '0, '0, '0, 0, 1, 1));
    send_request(make_request(OP_FAULT, 48'h2000_0010, '0, '0, '0, 0, 1, 1));
    send_request(make_request(OP_NOTE, 48'h1000, '0, '0, 4'd0, 0, 0, 1));
    send_request(make_request(OP_NOTE, 48'h1000, 48'h1000, '0, 4'd15, 0, 0, 1));
  endtask

  task automatic test_random_traffic(int count, bit with_idle);
    in_word_t w;
    for (int n = 0; n < count; n++) begin
      if (n % 100 == 0) idle_on = with_idle && ($urandom_range(0, 2) != 0);
      send_request(random_request());
      // map the page that was just asked for, as software would
      if (last_verdict.status == ST_COMMIT && $urandom_range(0, 3) != 0) begin
        w = random_request();
        w.op = OP_NOTE;
        w.address = last_verdict.page_addr;
        w.length = ADDR_W'(PAGE_SZ);
        w.region_index = last_verdict.hit_index;
        send_request(w);
      end
    end
  endtask

  task automatic test_table_full();
    idle_on = 1'b1;
    while (region_count < NUM_REGIONS)
      send_request(make_request(OP_ADD, rand_addr(), rand_length() | 48'h1,
                                FLAG_W'($urandom_range(0, 7)), '0, 0, 0, 1));
    send_request(make_request(OP_ADD, 48'h4000, 48'h1000, RF_WR | RF_UP, '0, 0, 0, 1));
    send_request(make_request(OP_ADD, ADDR_MAX, ADDR_MAX, '1, '1, 1, 1, 1));
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    test_empty_table();
    test_region_kinds();
    test_random_traffic(950, 1'b1);
    test_table_full();
    test_random_traffic(150, 1'b0);
    in_valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("vm_region_fault_classifier_core test passed");
    end else begin
      $display("vm_region_fault_classifier_core test failed");
    end
    $finish;
  end

endmodule
